// File: hw/rtl/lkv_pkg.sv
`timescale 1ns / 1ps
package lkv_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int AGE_W   = IDX_W;
  localparam int FILL_W  = $clog2(ENTRIES + 1);
  localparam int CAP_W   = 5;
  localparam int CNT_W   = (FILL_W > CAP_W) ? FILL_W : CAP_W;
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic OP_GET = 1'b0;
  localparam logic OP_SET = 1'b1;

  // partial search result handed from cell to cell
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] hit_slot;
    logic [AGE_W-1:0] hit_age;
    logic [VAL_W-1:0] hit_value;
    logic             free_found;
    logic [IDX_W-1:0] free_slot;
    logic             max_found;
    logic [IDX_W-1:0] max_slot;
    logic [AGE_W-1:0] max_age;
    logic [KEY_W-1:0] max_key;
  } scan_t;

  // update broadcast to every cell
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] slot;
    logic [AGE_W:0]   limit;
    logic             wr_key;
    logic             wr_value;
    logic             set_valid;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } cmd_t;

endpackage

// File: hw/rtl/lkv_cell.sv
`timescale 1ns / 1ps
module lkv_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [lkv_pkg::IDX_W-1:0] cell_idx_i,
  input  logic [lkv_pkg::KEY_W-1:0] key_i,
  input  lkv_pkg::scan_t            scan_i,
  input  lkv_pkg::cmd_t             cmd_i,
  output lkv_pkg::scan_t            scan_o
);

  logic                      valid_q;
  logic [lkv_pkg::AGE_W-1:0] age_q;
  logic [lkv_pkg::KEY_W-1:0] key_q;
  logic [lkv_pkg::VAL_W-1:0] value_q;
  lkv_pkg::scan_t            scan_d, scan_q;
  logic                      sel;

  assign sel = cmd_i.en && (cmd_i.slot == cell_idx_i);

  always_comb begin
    scan_d = scan_i;
    if (valid_q && (key_q == key_i) && !scan_i.found) begin
      scan_d.found     = 1'b1;
      scan_d.hit_slot  = cell_idx_i;
      scan_d.hit_age   = age_q;
      scan_d.hit_value = value_q;
    end
    // lowest free slot wins, so only the first one seen is kept
    if (!valid_q && !scan_i.free_found) begin
      scan_d.free_found = 1'b1;
      scan_d.free_slot  = cell_idx_i;
    end
    if (valid_q && (!scan_i.max_found || (age_q > scan_i.max_age))) begin
      scan_d.max_found = 1'b1;
      scan_d.max_slot  = cell_idx_i;
      scan_d.max_age   = age_q;
      scan_d.max_key   = key_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      age_q   <= '0;
    end else if (sel) begin
      age_q <= '0;
      if (cmd_i.set_valid) begin
        valid_q <= 1'b1;
      end
    end else if (cmd_i.en && valid_q && ({1'b0, age_q} < cmd_i.limit)) begin
      age_q <= age_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q <= scan_d;
    if (sel && cmd_i.wr_key) begin
      key_q <= cmd_i.key;
    end
    if (sel && cmd_i.wr_value) begin
      value_q <= cmd_i.value;
    end
  end

  assign scan_o = scan_q;

endmodule

// File: hw/rtl/lru_key_value_cache.sv
`timescale 1ns / 1ps
// channel   direction  transfer carries
// s_axis    in         tuser: operation; tdata: key, value
// m_axis    out        tuser: hit, evicted; tdata: read_value, evicted_key
// cfg       in         capacity, written whenever cfg_we_i is high
//
// one item passes through accept, then a search that ripples one cell per cycle
// down the chain, then the update.
// the update waits while a previous result is still held on m_axis.
// a new item can be accepted while a result waits to be taken.
// reset clears all valid marks and ages at once; no clearing pass.
module lru_key_value_cache (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [lkv_pkg::CAP_W-1:0] cfg_wdata_i,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [63:0]               s_axis_tdata,  // key, value
  input  logic [0:0]                s_axis_tuser,  // operation
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [63:0]               m_axis_tdata,  // read_value, evicted_key
  output logic [1:0]                m_axis_tuser   // hit, evicted
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_UPDATE
  } state_e;

  localparam logic [lkv_pkg::IDX_W-1:0] LAST_CNT = lkv_pkg::IDX_W'(lkv_pkg::ENTRIES - 1);

  state_e                       state_q;
  logic [lkv_pkg::IDX_W-1:0]    cnt_q;
  logic [lkv_pkg::FILL_W-1:0]   fill_q;
  logic [lkv_pkg::CAP_W-1:0]    cap_q;
  logic                         op_q;
  logic [lkv_pkg::KEY_W-1:0]    key_q;
  logic [lkv_pkg::VAL_W-1:0]    val_q;

  lkv_pkg::scan_t               chain [lkv_pkg::ENTRIES+1];
  lkv_pkg::scan_t               res;
  lkv_pkg::cmd_t                cmd, cmd_w;
  logic [lkv_pkg::CNT_W-1:0]    eff_cap;
  logic                         full;
  logic                         fire;
  logic                         r_hit, r_ev, fill_inc;
  logic [lkv_pkg::VAL_W-1:0]    r_rd;
  logic [lkv_pkg::KEY_W-1:0]    r_evk;

  assign chain[0] = '0;
  assign res      = chain[lkv_pkg::ENTRIES];

  for (genvar g = 0; g < lkv_pkg::ENTRIES; g++) begin : g_cell
    lkv_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (lkv_pkg::IDX_W'(g)),
      .key_i      (key_q),
      .scan_i     (chain[g]),
      .cmd_i      (cmd_w),
      .scan_o     (chain[g+1])
    );
  end

  always_comb begin
    if (cap_q == '0) begin
      eff_cap = lkv_pkg::CNT_W'(1);
    end else if (lkv_pkg::CNT_W'(cap_q) > lkv_pkg::CNT_W'(lkv_pkg::ENTRIES)) begin
      eff_cap = lkv_pkg::CNT_W'(lkv_pkg::ENTRIES);
    end else begin
      eff_cap = lkv_pkg::CNT_W'(cap_q);
    end
  end

  assign full = lkv_pkg::CNT_W'(fill_q) >= eff_cap;
  assign fire = (state_q == ST_UPDATE) && (!m_axis_tvalid || m_axis_tready);

  always_comb begin
    cmd       = '0;
    cmd.key   = key_q;
    cmd.value = val_q;
    r_hit     = 1'b0;
    r_rd      = '0;
    r_ev      = 1'b0;
    r_evk     = '0;
    fill_inc  = 1'b0;
    case (op_q)
      lkv_pkg::OP_GET: begin
        if (res.found) begin
          r_hit     = 1'b1;
          r_rd      = res.hit_value;
          cmd.en    = 1'b1;
          cmd.slot  = res.hit_slot;
          cmd.limit = {1'b0, res.hit_age};
        end else begin
          r_rd = '1;
        end
      end
      lkv_pkg::OP_SET: begin
        cmd.en       = 1'b1;
        cmd.wr_value = 1'b1;
        if (res.found) begin
          r_hit     = 1'b1;
          cmd.slot  = res.hit_slot;
          cmd.limit = {1'b0, res.hit_age};
        end else if (full) begin
          r_ev       = 1'b1;
          r_evk      = res.max_key;
          cmd.slot   = res.max_slot;
          cmd.limit  = {1'b0, res.max_age};
          cmd.wr_key = 1'b1;
        end else begin
          // insert into the lowest free slot, every valid entry ages
          cmd.slot      = res.free_slot;
          cmd.limit     = (lkv_pkg::AGE_W + 1)'(lkv_pkg::ENTRIES);
          cmd.wr_key    = 1'b1;
          cmd.set_valid = 1'b1;
          fill_inc      = 1'b1;
        end
      end
      default: begin
        cmd.en = 1'b0;
      end
    endcase
  end

  always_comb begin
    cmd_w    = cmd;
    cmd_w.en = cmd.en && fire;
  end

  assign s_axis_tready = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      cnt_q         <= '0;
      fill_q        <= '0;
      cap_q         <= lkv_pkg::CAP_RESET;
      op_q          <= lkv_pkg::OP_GET;
      key_q         <= '0;
      val_q         <= '0;
      m_axis_tvalid <= 1'b0;
      m_axis_tdata  <= '0;
      m_axis_tuser  <= '0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (m_axis_tvalid && m_axis_tready && !fire) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            op_q    <= s_axis_tuser[0];
            key_q   <= s_axis_tdata[31:0];
            val_q   <= s_axis_tdata[63:32];
            cnt_q   <= '0;
            state_q <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          // once cnt_q has stepped through every cell, the last cell holds the full answer
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == LAST_CNT) begin
            state_q <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (fire) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {r_evk, r_rd};
            m_axis_tuser  <= {r_ev, r_hit};
            if (fill_inc) begin
              fill_q <= fill_q + 1'b1;
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/lkv_checker.sv
`timescale 1ns / 1ps
module lkv_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [63:0]               m_axis_tdata,
  input logic [1:0]                m_axis_tuser
);

  // a held result does not change
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // one item at a time: no transfer right after another
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while busy");

  a_evict_not_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("eviction reported on a hit");

  a_evkey_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tdata[63:32] == 32'd0)
    else $error("evicted key nonzero without eviction");

  a_evict_rd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata[31:0] == 32'd0)
    else $error("read value nonzero on eviction");

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (.*);
